### hdl/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Shared widths and reset values of the centred moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

  // Sample and result value width
  localparam int DATA_W = 32;

  // Width of the window radius register as written on the configuration port
  localparam int CFG_W = 6;

  // Radius after reset
  localparam int RADIUS_RST = 1;

endpackage

### hdl/cma_if.sv
// ----------------------------------------------------------------------------
// cma_in_if / cma_out_if
// Valid/ready channels for frame samples and for smoothed results.
// ----------------------------------------------------------------------------
interface cma_in_if;
  import cma_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample_value;
  logic              frame_present;
  logic              last_frame;

  modport source (output valid, output sample_value, output frame_present,
                  output last_frame, input ready);
  modport sink   (input valid, input sample_value, input frame_present,
                  input last_frame, output ready);
endinterface

interface cma_out_if;
  import cma_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] smoothed_value;
  logic              center_present;
  logic              last_result;

  modport source (output valid, output smoothed_value, output center_present,
                  output last_result, input ready);
  modport sink   (input valid, input smoothed_value, input center_present,
                  input last_result, output ready);
endinterface

### hdl/cma_div.sv
// ----------------------------------------------------------------------------
// cma_div
// Iterative restoring divider: signed numerator by unsigned non-zero
// denominator, one quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module cma_div #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int ITER_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic              neg_q, neg_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              busy_q, busy_d;
  logic [DEN_W:0]    shifted;
  logic              ge;

  // one restoring step
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    iter_d = iter_q;
    busy_d = busy_q;
    if (start_i) begin
      neg_d  = num_i[NUM_W-1];
      quo_d  = num_i[NUM_W-1] ? (~num_i + NUM_W'(1)) : num_i;
      rem_d  = '0;
      den_d  = den_i;
      iter_d = ITER_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[NUM_W-2:0], ge};
      rem_d  = ge ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
      iter_d = iter_q - ITER_W'(1);
      busy_d = (iter_q != ITER_W'(1));
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? (~quo_q + NUM_W'(1)) : quo_q;

endmodule

### hdl/cma_line.sv
// ----------------------------------------------------------------------------
// cma_line
// Circular frame store: value memory plus written and present flags per
// slot. One write and one registered read per cycle; a slot never written
// since the last clear reads as an absent frame of value zero.
// ----------------------------------------------------------------------------
module cma_line #(
  parameter int DEPTH = 65
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clear_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  logic [cma_pkg::DATA_W-1:0]       wr_value_i,
  input  logic                             wr_present_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  output logic [cma_pkg::DATA_W-1:0]       rd_value_o,
  output logic                             rd_present_o
);
  import cma_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  written_q;
  logic [DEPTH-1:0]  present_q;
  logic [DATA_W-1:0] rd_mem_q;
  logic              rd_written_q;
  logic              rd_present_q;

  // value memory, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_value_i;
    end
    rd_mem_q <= mem_q[rd_addr_i];
  end

  // per-slot flags, cleared at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      present_q    <= '0;
      rd_written_q <= 1'b0;
      rd_present_q <= 1'b0;
    end else begin
      rd_written_q <= written_q[rd_addr_i];
      rd_present_q <= written_q[rd_addr_i] & present_q[rd_addr_i];
      if (clear_i) begin
        written_q <= '0;
        present_q <= '0;
      end else if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
        present_q[wr_addr_i] <= wr_present_i;
      end
    end
  end

  assign rd_value_o   = rd_written_q ? rd_mem_q : '0;
  assign rd_present_o = rd_present_q;

endmodule

### hdl/centered_moving_average_gaps.sv
// ----------------------------------------------------------------------------
// centered_moving_average_gaps
// Centred boxcar moving average over a frame stream with missing frames.
// ----------------------------------------------------------------------------
// Takes one frame per input transfer and, once r frames of the stream have
// gone in, returns the result for the frame r places back: the truncated
// mean of the present frames in the 2r+1 window, or the frame's own value
// when it is absent. The end-of-stream mark flushes the r trailing centres
// and clears the window. Frames are held in a circular store and every
// averaged result goes through one shared restoring divider that yields a
// quotient bit per cycle over 39 steps. A result for an absent centre skips
// the divider, and a frame at stream start that produces nothing ends once
// it is stored. A frame with the end mark then runs the centre pass once
// more for each of the r flushed centres. The input is not ready while a
// frame is in work; a finished result waits in the output register without
// stopping the next frame. Writing the radius clears the window at once,
// with no clearing pass.
module centered_moving_average_gaps #(
  parameter int MAX_RADIUS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cma_pkg::CFG_W-1:0] cfg_wdata_i,
  cma_in_if.sink                    in_i,
  cma_out_if.source                 out_o
);
  import cma_pkg::*;

  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = DATA_W + $clog2(DEPTH);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_EDGE = 9'b000000010,
    ST_SUB  = 9'b000000100,
    ST_ADD  = 9'b000001000,
    ST_CTR  = 9'b000010000,
    ST_CTRW = 9'b000100000,
    ST_DIV  = 9'b001000000,
    ST_OUT  = 9'b010000000,
    ST_NEXT = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [RAD_W-1:0]  radius_q, radius_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [RAD_W-1:0]  seen_q, seen_d;
  logic [RAD_W-1:0]  flush_q, flush_d;
  logic              last_q, last_d;
  logic [DATA_W-1:0] adv_val_q, adv_val_d;
  logic              adv_pres_q, adv_pres_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic              ctr_pres_q, ctr_pres_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  logic              out_pres_q, out_pres_d;
  logic              out_last_q, out_last_d;

  logic              clear;
  logic [31:0]       cfg_sat;
  logic [PTR_W:0]    back;
  logic [PTR_W:0]    diff;
  logic [PTR_W-1:0]  rd_addr;
  logic [PTR_W-1:0]  head_inc;
  logic              wr_en;
  logic [DATA_W-1:0] rd_value;
  logic              rd_present;
  logic              div_start;
  logic              div_busy;
  logic [SUM_W-1:0]  div_quo;

  // frame store
  cma_line #(.DEPTH(DEPTH)) u_line (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (clear),
    .wr_en_i      (wr_en),
    .wr_addr_i    (head_inc),
    .wr_value_i   (adv_val_q),
    .wr_present_i (adv_pres_q),
    .rd_addr_i    (rd_addr),
    .rd_value_o   (rd_value),
    .rd_present_o (rd_present)
  );

  // shared divider
  cma_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (count_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // radius saturates to the store limit
  assign cfg_sat = (32'(cfg_wdata_i) > 32'(MAX_RADIUS)) ? 32'(MAX_RADIUS)
                                                        : 32'(cfg_wdata_i);

  // read address: edge slot 2r back, centre slot r back, modulo depth
  assign back     = (state_q == ST_EDGE) ? (PTR_W+1)'({radius_q, 1'b0})
                                         : (PTR_W+1)'(radius_q);
  assign diff     = {1'b0, head_q} - back;
  assign rd_addr  = diff[PTR_W] ? PTR_W'(diff + (PTR_W+1)'(DEPTH)) : diff[PTR_W-1:0];
  assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

  assign wr_en     = (state_q == ST_ADD);
  assign div_start = (state_q == ST_CTRW) && rd_present && (count_q != '0);

  assign in_i.ready = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    radius_d    = radius_q;
    head_d      = head_q;
    sum_d       = sum_q;
    count_d     = count_q;
    seen_d      = seen_q;
    flush_d     = flush_q;
    last_d      = last_q;
    adv_val_d   = adv_val_q;
    adv_pres_d  = adv_pres_q;
    res_d       = res_q;
    ctr_pres_d  = ctr_pres_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_pres_d  = out_pres_q;
    out_last_d  = out_last_q;
    clear       = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          adv_val_d  = in_i.sample_value;
          adv_pres_d = in_i.frame_present;
          last_d     = in_i.last_frame;
          flush_d    = in_i.last_frame ? radius_q : '0;
          state_d    = ST_EDGE;
        end
      end
      ST_EDGE: state_d = ST_SUB;
      // drop the frame leaving the window
      ST_SUB: begin
        if (rd_present) begin
          sum_d   = sum_q - {{(SUM_W-DATA_W){rd_value[DATA_W-1]}}, rd_value};
          count_d = count_q - CNT_W'(1);
        end
        state_d = ST_ADD;
      end
      // store the new frame and add it in
      ST_ADD: begin
        head_d = head_inc;
        if (adv_pres_q) begin
          sum_d   = sum_q + {{(SUM_W-DATA_W){adv_val_q[DATA_W-1]}}, adv_val_q};
          count_d = count_q + CNT_W'(1);
        end
        if (seen_q < radius_q) begin
          seen_d  = seen_q + RAD_W'(1);
          state_d = ST_NEXT;
        end else begin
          state_d = ST_CTR;
        end
      end
      ST_CTR: state_d = ST_CTRW;
      // centre frame read back
      ST_CTRW: begin
        ctr_pres_d = rd_present;
        res_d      = rd_value;
        state_d    = div_start ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (!div_busy) begin
          res_d   = div_quo[DATA_W-1:0];
          state_d = ST_OUT;
        end
      end
      // hand the result to the output register
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = res_q;
          out_pres_d  = ctr_pres_q;
          out_last_d  = last_q && (flush_q == '0);
          state_d     = ST_NEXT;
        end
      end
      // flush step, end of stream, or back to idle
      ST_NEXT: begin
        if (flush_q != '0) begin
          flush_d    = flush_q - RAD_W'(1);
          adv_val_d  = '0;
          adv_pres_d = 1'b0;
          state_d    = ST_EDGE;
        end else begin
          clear   = last_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // radius write clears the stream
    if (cfg_we_i) begin
      radius_d = cfg_sat[RAD_W-1:0];
      clear    = 1'b1;
    end

    if (clear) begin
      sum_d   = '0;
      count_d = '0;
      seen_d  = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= RAD_W'(RADIUS_RST);
      head_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      seen_q      <= '0;
      flush_q     <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      radius_q    <= radius_d;
      head_q      <= head_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      seen_q      <= seen_d;
      flush_q     <= flush_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    adv_val_q   <= adv_val_d;
    adv_pres_q  <= adv_pres_d;
    res_q       <= res_d;
    ctr_pres_q  <= ctr_pres_d;
    out_value_q <= out_value_d;
    out_pres_q  <= out_pres_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.smoothed_value = out_value_q;
  assign out_o.center_present = out_pres_q;
  assign out_o.last_result    = out_last_q;

endmodule
